// File: src/bitmap_inode_block_allocator_macros.svh
// Assertion macros for the bitmap inode and block allocator.
`ifndef BITMAP_INODE_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_INODE_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BIBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define BIBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/biba_pkg.sv
// Shared types and constants for the bitmap inode and block allocator.
package biba_pkg;

   localparam int FIELD_W = 14;
   localparam logic [FIELD_W-1:0] COUNT_RESET = 14'd8192;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic POOL_INODE = 1'b0;
   localparam logic POOL_BLOCK = 1'b1;

   localparam logic CSR_INODE_COUNT = 1'b0;
   localparam logic CSR_BLOCK_COUNT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_RANGE   = 2'd2,
      STATUS_ALREADY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FCHK
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic clr_wr;
      logic scan_rd;
      logic free_rd;
      logic fin_alloc;
      logic fin_full;
      logic fin_free;
      logic fin_range;
      logic fin_already;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_done;
      logic is_free;
      logic cnt_zero;
      logic range_bad;
      logic found;
      logic chk_last;
      logic bit_set;
      logic out_free;
   } sts_type;

endpackage

// File: src/biba_ctrl.sv
// Sequencing state machine for the bitmap allocator.
module biba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  biba_pkg::sts_type sts,
   output biba_pkg::cmd_type cmd
);

   biba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= biba_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         biba_pkg::S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_done) begin
               state_in = biba_pkg::S_IDLE;
            end
         end
         biba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = biba_pkg::S_DECODE;
            end
         end
         biba_pkg::S_DECODE: begin
            if (!sts.is_free) begin
               if (!sts.cnt_zero) begin
                  cmd.scan_rd = 1'b1;
                  state_in    = biba_pkg::S_SCAN;
               end else if (sts.out_free) begin
                  cmd.fin_full = 1'b1;
                  state_in     = biba_pkg::S_IDLE;
               end
            end else begin
               if (!sts.range_bad) begin
                  cmd.free_rd = 1'b1;
                  state_in    = biba_pkg::S_FCHK;
               end else if (sts.out_free) begin
                  cmd.fin_range = 1'b1;
                  state_in      = biba_pkg::S_IDLE;
               end
            end
         end
         biba_pkg::S_SCAN: begin
            // read data holds while stalled: no read is issued
            priority if (sts.found) begin
               if (sts.out_free) begin
                  cmd.fin_alloc = 1'b1;
                  state_in      = biba_pkg::S_IDLE;
               end
            end else if (sts.chk_last) begin
               if (sts.out_free) begin
                  cmd.fin_full = 1'b1;
                  state_in     = biba_pkg::S_IDLE;
               end
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         biba_pkg::S_FCHK: begin
            if (sts.out_free) begin
               if (sts.bit_set) begin
                  cmd.fin_free = 1'b1;
               end else begin
                  cmd.fin_already = 1'b1;
               end
               state_in = biba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = biba_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

// File: src/biba_dp.sv
// Datapath: bitmap memory, word scan, use counters and result register.
module biba_dp #(
   parameter int MAX_ENTRIES = 8192,
   parameter int WORD_BITS   = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_func,
   input  logic                         req_pool,
   input  logic [biba_pkg::FIELD_W-1:0] req_number,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [biba_pkg::FIELD_W-1:0] csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [biba_pkg::FIELD_W-1:0] rsp_number_res,
   output logic [1:0]                   rsp_status,
   output logic [biba_pkg::FIELD_W-1:0] rsp_free_count,
   input  biba_pkg::cmd_type            cmd,
   output biba_pkg::sts_type            sts
);

   localparam int FW        = biba_pkg::FIELD_W;
   localparam int NWORDS    = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int AW        = WA + 1;
   localparam int MEM_DEPTH = 2 ** AW;
   localparam int BIW       = $clog2(WORD_BITS);

   // configuration
   logic [FW-1:0] inode_count_ff, block_count_ff;

   // item under work
   logic          func_ff, pool_ff;
   logic [FW-1:0] number_ff, count_ff, rem_ff;
   logic [WA-1:0] rd_ptr_ff, chk_ptr_ff;
   logic [FW-1:0] rd_left_ff, chk_left_ff;
   logic [AW-1:0] clr_ptr_ff;

   // bitmap store, both pools: address is {pool, word}
   logic [WORD_BITS-1:0] mem [MEM_DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   logic [FW-1:0] inodes_used_ff, blocks_used_ff;

   logic             rsp_valid_ff;
   logic [FW-1:0]    number_res_ff, free_count_ff;
   biba_pkg::status_type status_ff;

   logic [FW-1:0]        raw_count, eff_count;
   logic [WORD_BITS-1:0] avail;
   logic                 found;
   logic [BIW-1:0]       found_bit;
   logic [FW-1:0]        used_sel, used_new, freec;
   logic [WA-1:0]        free_word;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic                 fin_any, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_count_ff <= biba_pkg::COUNT_RESET;
         block_count_ff <= biba_pkg::COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == biba_pkg::CSR_INODE_COUNT) begin
            inode_count_ff <= csr_wdata;
         end else begin
            block_count_ff <= csr_wdata;
         end
      end
   end

   // count registers above the store size act as the store size
   always_comb begin
      raw_count = (req_pool == biba_pkg::POOL_BLOCK) ? block_count_ff : inode_count_ff;
      eff_count = (32'(raw_count) > MAX_ENTRIES) ? FW'(MAX_ENTRIES) : raw_count;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         pool_ff    <= req_pool;
         number_ff  <= req_number;
         count_ff   <= eff_count;
         rem_ff     <= req_number - FW'(1);
         rd_ptr_ff  <= '0;
         rd_left_ff <= eff_count;
      end else if (cmd.scan_rd) begin
         chk_ptr_ff  <= rd_ptr_ff;
         chk_left_ff <= rd_left_ff;
         rd_ptr_ff   <= rd_ptr_ff + WA'(1);
         rd_left_ff  <= rd_left_ff - FW'(WORD_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ptr_ff <= clr_ptr_ff + AW'(1);
      end
   end

   // lowest clear bit of the word under check that lies below the count
   always_comb begin
      found     = 1'b0;
      found_bit = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         avail[j] = !rd_data_ff[j] && (j < 32'(chk_left_ff));
      end
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (avail[j]) begin
            found     = 1'b1;
            found_bit = BIW'(j);
         end
      end
   end

   // number - 1 splits into word (upper bits) and bit (lower bits)
   assign free_word = WA'(rem_ff >> BIW);

   always_comb begin
      rd_en   = cmd.scan_rd | cmd.free_rd;
      rd_addr = cmd.free_rd ? {pool_ff, free_word} : {pool_ff, rd_ptr_ff};
      wr_en   = cmd.clr_wr | cmd.fin_alloc | cmd.fin_free;
      priority if (cmd.clr_wr) begin
         wr_addr = clr_ptr_ff;
         wr_data = '0;
      end else if (cmd.fin_alloc) begin
         wr_addr = {pool_ff, chk_ptr_ff};
         wr_data = rd_data_ff | (WORD_BITS'(1) << found_bit);
      end else begin
         wr_addr = {pool_ff, free_word};
         wr_data = rd_data_ff & ~(WORD_BITS'(1) << rem_ff[BIW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // use counters and free count after this item
   always_comb begin
      used_sel = (pool_ff == biba_pkg::POOL_BLOCK) ? blocks_used_ff : inodes_used_ff;
      priority if (cmd.fin_alloc) begin
         used_new = used_sel + FW'(1);
      end else if (cmd.fin_free && used_sel != '0) begin
         used_new = used_sel - FW'(1);
      end else begin
         used_new = used_sel;
      end
      freec = (count_ff > used_new) ? count_ff - used_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inodes_used_ff <= '0;
         blocks_used_ff <= '0;
      end else if (cmd.fin_alloc || cmd.fin_free) begin
         if (pool_ff == biba_pkg::POOL_BLOCK) begin
            blocks_used_ff <= used_new;
         end else begin
            inodes_used_ff <= used_new;
         end
      end
   end

   assign fin_any  = cmd.fin_alloc | cmd.fin_full | cmd.fin_free | cmd.fin_range
                   | cmd.fin_already;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_any) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_any) begin
         free_count_ff <= freec;
         number_res_ff <= cmd.fin_alloc
                        ? count_ff - chk_left_ff + FW'(found_bit) + FW'(1) : '0;
         priority if (cmd.fin_alloc || cmd.fin_free) begin
            status_ff <= biba_pkg::STATUS_OK;
         end else if (cmd.fin_full) begin
            status_ff <= biba_pkg::STATUS_FULL;
         end else if (cmd.fin_range) begin
            status_ff <= biba_pkg::STATUS_RANGE;
         end else begin
            status_ff <= biba_pkg::STATUS_ALREADY;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_number_res = number_res_ff;
   assign rsp_status     = status_ff;
   assign rsp_free_count = free_count_ff;

   always_comb begin
      sts.clr_done  = &clr_ptr_ff;
      sts.is_free   = (func_ff == biba_pkg::FUNC_FREE);
      sts.cnt_zero  = (count_ff == '0);
      sts.range_bad = (number_ff == '0) || (number_ff > count_ff);
      sts.found     = found;
      sts.chk_last  = (32'(chk_left_ff) <= WORD_BITS);
      sts.bit_set   = rd_data_ff[rem_ff[BIW-1:0]];
      sts.out_free  = out_free;
   end

endmodule

// File: src/bitmap_inode_block_allocator.sv
// Top level of the two-pool bitmap first-fit allocator.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_func, req_pool, req_number
//   rsp      out        rsp_valid/rsp_ready    rsp_number_res, rsp_status, rsp_free_count
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One item at a time. An allocate reads and checks the bitmap words in turn, up to
// ceil(count / WORD_BITS) words, one word a cycle through the memory read port.
// A free reads the word that holds its bit: number - 1 splits into word and bit by
// shift and mask, so WORD_BITS must be a power of two; the block does not check it.
// A free out of range or an allocate on an empty pool finishes from decode. After
// reset a clearing pass writes every bitmap word, 256 at the defaults, before the first
// item is taken. A result held by a stalled rsp side stalls only the next item's finish.
`include "bitmap_inode_block_allocator_macros.svh"

module bitmap_inode_block_allocator #(
   parameter int MAX_ENTRIES = 8192,
   parameter int WORD_BITS   = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic                         req_pool,
   input  logic [biba_pkg::FIELD_W-1:0] req_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [biba_pkg::FIELD_W-1:0] rsp_number_res,
   output logic [1:0]                   rsp_status,
   output logic [biba_pkg::FIELD_W-1:0] rsp_free_count,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [biba_pkg::FIELD_W-1:0] csr_wdata
);

   biba_pkg::cmd_type cmd;
   biba_pkg::sts_type sts;
   logic [4:0]        fin_vec;
   logic              fin_any;

   biba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   biba_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WORD_BITS   (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_pool       (req_pool),
      .req_number     (req_number),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_number_res (rsp_number_res),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count),
      .cmd            (cmd),
      .sts            (sts)
   );

   assign fin_vec = {cmd.fin_alloc, cmd.fin_full, cmd.fin_free, cmd.fin_range,
                     cmd.fin_already};
   assign fin_any = |fin_vec;

   `BIBA_ASSERT_NOW(a_fin_needs_room, clock, reset, fin_any, sts.out_free, "result overwritten")
   `BIBA_ASSERT_NOW(a_one_fin, clock, reset, 1'b1, $onehot0(fin_vec), "several finishes")
   `BIBA_ASSERT_NOW(a_alloc_found, clock, reset, cmd.fin_alloc, sts.found, "no clear bit")
   `BIBA_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "busy")

endmodule

// File: test/allocator_checker.sv
// Checker for the two-pool bitmap allocator: tracks both bitmaps and checks every result.
`timescale 1ns / 1ps

module allocator_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_func,
   input  logic                         req_pool,
   input  logic [biba_pkg::FIELD_W-1:0] req_number,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [biba_pkg::FIELD_W-1:0] rsp_number_res,
   input  logic [1:0]                   rsp_status,
   input  logic [biba_pkg::FIELD_W-1:0] rsp_free_count,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [biba_pkg::FIELD_W-1:0] csr_wdata,
   output int                           outstanding,
   output int                           mismatches
);

   localparam int MAX_ENTRIES = 8192;

   typedef logic [biba_pkg::FIELD_W-1:0] field_type;

   typedef struct {
      field_type            number_res;
      biba_pkg::status_type status;
      field_type            free_count;
   } outcome_type;

   bit          pool_map [2][MAX_ENTRIES];
   int          used_count [2];
   field_type   count_reg [2];
   outcome_type awaited [$];

   // Allocates or frees in the shadow bitmaps and returns the result the block owes.
   function automatic outcome_type apply_request(input logic func, input logic pool,
                                                 input field_type number);
      outcome_type o;
      int          lim;
      int          i;
      bit          hit;
      o.number_res = '0;
      o.status     = biba_pkg::STATUS_OK;
      hit          = 1'b0;
      lim = (count_reg[pool] > MAX_ENTRIES) ? MAX_ENTRIES : int'(count_reg[pool]);
      if (func == biba_pkg::FUNC_ALLOC) begin
         o.status = biba_pkg::STATUS_FULL;
         for (i = 0; i < lim && !hit; i++) begin
            if (!pool_map[pool][i]) begin
               pool_map[pool][i] = 1'b1;
               used_count[pool]++;
               o.number_res = field_type'(i + 1);
               o.status     = biba_pkg::STATUS_OK;
               hit          = 1'b1;
            end
         end
      end else if (number == 0 || int'(number) > lim) begin
         o.status = biba_pkg::STATUS_RANGE;
      end else if (!pool_map[pool][number - 1]) begin
         o.status = biba_pkg::STATUS_ALREADY;
      end else begin
         pool_map[pool][number - 1] = 1'b0;
         if (used_count[pool] > 0) used_count[pool]--;
      end
      // free count saturates once the count is lowered below the used total
      o.free_count = (lim > used_count[pool]) ? field_type'(lim - used_count[pool]) : '0;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (pool_map[p, i]) pool_map[p][i] = 1'b0;
         used_count[0] = 0;
         used_count[1] = 0;
         count_reg[0]  = biba_pkg::COUNT_RESET;
         count_reg[1]  = biba_pkg::COUNT_RESET;
         awaited.delete();
         outstanding = 0;
         mismatches  = 0;
      end else begin
         if (csr_we) count_reg[csr_index] = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               $error("result item with nothing outstanding: number_res %0d status %0d",
                      rsp_number_res, rsp_status);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               outstanding--;
               if (rsp_number_res !== want.number_res) begin
                  $error("number_res: expected %0d, got %0d", want.number_res, rsp_number_res);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_free_count !== want.free_count) begin
                  $error("free_count: expected %0d, got %0d", want.free_count, rsp_free_count);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited.push_back(apply_request(req_func, req_pool, req_number));
            outstanding++;
         end
      end
   end

endmodule

// File: test/testbench.sv
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

   typedef logic [biba_pkg::FIELD_W-1:0] field_type;

   localparam int LONG_HOLD = 300;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   logic      req_func;
   logic      req_pool;
   field_type req_number;
   logic      rsp_valid;
   logic      rsp_ready;
   field_type rsp_number_res;
   logic [1:0] rsp_status;
   field_type rsp_free_count;
   logic      csr_we;
   logic      csr_index;
   field_type csr_wdata;

   int        outstanding;
   int        mismatches;
   bit        no_idle;
   bit        rx_hold_wanted;
   field_type cfg_count [2];

   bitmap_inode_block_allocator DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_pool       (req_pool),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_number_res (rsp_number_res),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   allocator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_pool       (req_pool),
      .req_number     (req_number),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_number_res (rsp_number_res),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatches     (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("** bitmap_inode_block_allocator: FAILED **");
      $finish;
   end

   // Presents one item after a random gap and returns at the edge that takes it.
   task automatic offer(input logic func, input logic pool, input field_type number);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_func   <= func;
      req_pool   <= pool;
      req_number <= number;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits for every outstanding result.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_count(input logic idx, input field_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      cfg_count[idx] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic field_type pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return '0;
      if (roll < 6) return 1;
      if (roll < 8) return 8192;
      if (roll < 10) return field_type'($urandom_range(8193, 16383));
      if (roll < 20) return field_type'($urandom_range(1, 8192));
      return field_type'($urandom_range(1, 96));
   endfunction

   // Mostly numbers within the pool, biased low where first-fit leaves entries in use.
   function automatic field_type free_target(input logic pool);
      int lim;
      int roll;
      lim  = (cfg_count[pool] > 8192) ? 8192 : int'(cfg_count[pool]);
      roll = $urandom_range(0, 99);
      if (roll < 6 || lim == 0) return field_type'($urandom_range(0, 16383));
      if (roll < 9) return '0;
      if (roll < 12) return field_type'(lim + $urandom_range(1, 3));
      if (roll < 55) return field_type'($urandom_range(1, (lim < 64) ? lim : 64));
      return field_type'($urandom_range(1, lim));
   endfunction

   // Result side: random stalls per item, plus one long hold-off on request.
   initial begin
      int stall;
      int held;
      rsp_ready = 1'b0;
      forever begin
         if (rx_hold_wanted) begin
            rx_hold_wanted = 1'b0;
            held = 0;
            while (held < LONG_HOLD) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
               held++;
            end
         end
         stall = no_idle ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int        phase;
      int        n;
      int        alloc_pct;
      logic      pool;
      field_type cnt;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = biba_pkg::FUNC_ALLOC;
      req_pool       = biba_pkg::POOL_INODE;
      req_number     = '0;
      csr_we         = 1'b0;
      csr_index      = biba_pkg::CSR_INODE_COUNT;
      csr_wdata      = '0;
      no_idle        = 1'b0;
      rx_hold_wanted = 1'b0;
      cfg_count[biba_pkg::POOL_INODE] = biba_pkg::COUNT_RESET;
      cfg_count[biba_pkg::POOL_BLOCK] = biba_pkg::COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default counts, range edges, double free, first-fit reuse
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_INODE, '0);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_BLOCK, 16383);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_INODE, '0);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, '0);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 8193);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_BLOCK, 16383);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 8192);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_BLOCK, 8192);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 1);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 1);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_INODE, '0);

      // one-entry inode pool below its used total, empty block pool
      settle();
      write_count(biba_pkg::CSR_INODE_COUNT, 1);
      write_count(biba_pkg::CSR_BLOCK_COUNT, 0);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_INODE, '0);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 2);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 1);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_INODE, '0);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_BLOCK, '0);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_BLOCK, 1);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_BLOCK, 0);

      // counts above the pool size act as the full size
      settle();
      write_count(biba_pkg::CSR_INODE_COUNT, 16383);
      write_count(biba_pkg::CSR_BLOCK_COUNT, 8193);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_INODE, '0);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 2);
      offer(biba_pkg::FUNC_ALLOC, biba_pkg::POOL_BLOCK, '0);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_BLOCK, 8192);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_INODE, 10921);
      offer(biba_pkg::FUNC_FREE,  biba_pkg::POOL_BLOCK, 5461);

      for (phase = 0; phase < 12; phase++) begin
         settle();
         cnt = pick_count();
         write_count(biba_pkg::CSR_INODE_COUNT, cnt);
         cnt = pick_count();
         write_count(biba_pkg::CSR_BLOCK_COUNT, cnt);
         no_idle   = (phase % 4 == 1);
         alloc_pct = $urandom_range(30, 85);
         // receiver stalls for a long stretch while items keep coming
         if (phase == 2) rx_hold_wanted = 1'b1;
         for (n = 0; n < 125; n++) begin
            if (phase == 5 && n == 60) settle();
            pool = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < alloc_pct)
               offer(biba_pkg::FUNC_ALLOC, pool, field_type'($urandom_range(0, 16383)));
            else
               offer(biba_pkg::FUNC_FREE, pool, free_target(pool));
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("** bitmap_inode_block_allocator: PASSED **");
      end else begin
         $display("** bitmap_inode_block_allocator: FAILED **");
      end
      $finish;
   end

endmodule
